/* sv/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: word layouts,
// function codes, cell constants and the sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int CELL_W = 16;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] DEF_ATTR     = 8'h0f;
  localparam logic [7:0] ERR_ATTR     = 8'hf4;
  localparam logic [7:0] ERR_CHAR     = 8'h45;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] ch;
    logic [7:0] attr;
    logic       at_cursor;
    logic [7:0] col;
    logic [5:0] row;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic       out_of_range;
    logic       scrolled;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } out_item_t;

  // operands for the shared address unit: addr = row * COLS + col
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } addr_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [CELL_W-1:0] wdata;
  } mem_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUT_WR,
    ST_RD_MEM,
    ST_RD_DATA,
    ST_CLR_ADR,
    ST_CLR_WR,
    ST_SCR_SRC,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_ZERO_ADR,
    ST_ZERO_WR,
    ST_FINISH
  } state_t;

endpackage

/* sv/text_console_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console: a COLS x ROWS grid of {char, attr} cells and a cursor.
//
// One word at a time. A put steps through DECODE, PUT_WR and FINISH; a read
// through DECODE, RD_MEM, RD_DATA and FINISH; an off-grid read, an unused
// function code or a newline that does not scroll goes from DECODE straight
// to FINISH. A held result keeps FINISH waiting until it is taken. A put
// that runs past the last cell scrolls: every cell is moved through the
// single-port store with one read and one write and two passes of the
// shared row*COLS+col address unit, for source and destination. A clear
// walks every cell with an address pass and a write. After reset the store
// is swept to spaces with attribute 0x0f, with in_ready low. A finished
// result sits in an output register, so the next word can be accepted
// before the result is taken.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcw_pkg::out_item_t  out_data
);
  import tcw_pkg::*;

  localparam int DEPTH  = COLS * ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  addr_req_t         addr_req;
  mem_ctrl_t         mem_ctrl;
  logic [ADDR_W-1:0] addr;
  logic [CELL_W-1:0] rdata;

  tcw_seq #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .addr_req (addr_req),
    .mem_ctrl (mem_ctrl),
    .rdata    (rdata)
  );

  tcw_addr_unit #(
    .COLS  (COLS),
    .ADDR_W(ADDR_W)
  ) u_addr (
    .clk (clk),
    .req (addr_req),
    .addr(addr)
  );

  tcw_cell_mem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk  (clk),
    .ctrl (mem_ctrl),
    .addr (addr),
    .rdata(rdata)
  );

endmodule

/* sv/tcw_addr_unit.sv */
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared multiply-add unit: registers row * COLS + col as a cell address.
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
  parameter int COLS   = tcw_pkg::DEF_COLS,
  parameter int ADDR_W = 11
) (
  input  logic                clk,
  input  tcw_pkg::addr_req_t  req,
  output logic [ADDR_W-1:0]   addr
);
  import tcw_pkg::*;

  localparam int SUM_W = ROW_W + COL_W;

  logic [SUM_W-1:0] sum;

  assign sum = req.row * SUM_W'(COLS) + SUM_W'(req.col);

  always_ff @(posedge clk) begin
    if (req.en) begin
      addr <= sum[ADDR_W-1:0];
    end
  end

endmodule

/* sv/tcw_cell_mem.sv */
// ----------------------------------------------------------------------------
// tcw_cell_mem
// Screen store: one cell per word, {char, attr}, registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_mem #(
  parameter int DEPTH  = tcw_pkg::DEF_COLS * tcw_pkg::DEF_ROWS,
  parameter int ADDR_W = 11
) (
  input  logic                        clk,
  input  tcw_pkg::mem_ctrl_t          ctrl,
  input  logic [ADDR_W-1:0]           addr,
  output logic [tcw_pkg::CELL_W-1:0]  rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[addr] <= ctrl.wdata;
    end
    if (ctrl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/tcw_seq.sv */
// ----------------------------------------------------------------------------
// tcw_seq
// Sequencer: decodes a word, keeps the cursor, walks the store for clear
// and scroll, and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module tcw_seq #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tcw_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tcw_pkg::out_item_t          out_data,
  output tcw_pkg::addr_req_t          addr_req,
  output tcw_pkg::mem_ctrl_t          mem_ctrl,
  input  logic [tcw_pkg::CELL_W-1:0]  rdata
);
  import tcw_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  state_t state, state_next;

  in_item_t         item;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] walk_col;
  logic [ROW_W-1:0] walk_row;
  logic             booting;
  logic             res_oor;
  logic             res_scr;
  logic [7:0]       res_char;
  logic [7:0]       res_attr;

  // decode of the held word
  logic             bad;
  logic [COL_W-1:0] tgt_col;
  logic [ROW_W-1:0] tgt_row;
  logic             is_nl;
  logic [COL_W-1:0] new_col;
  logic [ROW_W:0]   new_row_ext;
  logic             wrap;
  logic             walk_row_end;
  logic             walk_col_end;
  logic             out_free;

  assign bad = !item.at_cursor &&
               ((item.col >= 8'(COLS)) || ({1'b0, item.row} >= (ROW_W + 1)'(ROWS)));
  assign tgt_col = item.at_cursor ? cur_col : item.col[COL_W-1:0];
  assign tgt_row = item.at_cursor ? cur_row : item.row;
  assign is_nl   = (item.ch == NEWLINE_CHAR);

  always_comb begin
    if (is_nl || (tgt_col == LAST_COL)) begin
      new_col     = '0;
      new_row_ext = {1'b0, tgt_row} + 1'b1;
    end else begin
      new_col     = tgt_col + 1'b1;
      new_row_ext = {1'b0, tgt_row};
    end
  end

  assign wrap         = (new_row_ext == (ROW_W + 1)'(ROWS));
  assign walk_col_end = (walk_col == LAST_COL);
  assign walk_row_end = (walk_row == LAST_ROW);
  assign out_free     = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (item.func)
          FUNC_PUT: begin
            if (bad || !is_nl) state_next = ST_PUT_WR;
            else if (wrap)     state_next = (ROWS > 1) ? ST_SCR_SRC : ST_ZERO_ADR;
            else               state_next = ST_FINISH;
          end
          FUNC_CLEAR: state_next = ST_CLR_ADR;
          FUNC_READ:  state_next = bad ? ST_FINISH : ST_RD_MEM;
          default:    state_next = ST_FINISH;
        endcase
      end
      ST_PUT_WR: begin
        if (res_scr) state_next = (ROWS > 1) ? ST_SCR_SRC : ST_ZERO_ADR;
        else         state_next = ST_FINISH;
      end
      ST_RD_MEM:  state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_FINISH;
      ST_CLR_ADR: state_next = ST_CLR_WR;
      ST_CLR_WR: begin
        if (walk_row_end && walk_col_end) state_next = booting ? ST_IDLE : ST_FINISH;
        else                              state_next = ST_CLR_ADR;
      end
      ST_SCR_SRC: state_next = ST_SCR_RD;
      ST_SCR_RD:  state_next = ST_SCR_WR;
      ST_SCR_WR: begin
        if (walk_row_end && walk_col_end) state_next = ST_ZERO_ADR;
        else                              state_next = ST_SCR_SRC;
      end
      ST_ZERO_ADR: state_next = ST_ZERO_WR;
      ST_ZERO_WR:  state_next = walk_col_end ? ST_FINISH : ST_ZERO_ADR;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs toward the address unit and the store
  always_comb begin
    in_ready = 1'b0;
    addr_req = '0;
    mem_ctrl = '0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DECODE: begin
        addr_req.en = 1'b1;
        if ((item.func == FUNC_PUT) && bad) begin
          addr_req.row = LAST_ROW;
          addr_req.col = LAST_COL;
        end else begin
          addr_req.row = tgt_row;
          addr_req.col = tgt_col;
        end
      end
      ST_PUT_WR: begin
        mem_ctrl.we = 1'b1;
        if (res_oor) mem_ctrl.wdata = {ERR_CHAR, ERR_ATTR};
        else         mem_ctrl.wdata = {item.ch, (item.attr == 8'h00) ? DEF_ATTR : item.attr};
      end
      ST_RD_MEM: mem_ctrl.re = 1'b1;
      ST_CLR_ADR, ST_SCR_SRC: begin
        addr_req.en  = 1'b1;
        addr_req.row = walk_row;
        addr_req.col = walk_col;
      end
      ST_CLR_WR: begin
        mem_ctrl.we    = 1'b1;
        mem_ctrl.wdata = {SPACE_CHAR, DEF_ATTR};
      end
      ST_SCR_RD: begin
        // read the source while the unit forms the destination one row up
        mem_ctrl.re  = 1'b1;
        addr_req.en  = 1'b1;
        addr_req.row = walk_row - 1'b1;
        addr_req.col = walk_col;
      end
      ST_SCR_WR: begin
        mem_ctrl.we    = 1'b1;
        mem_ctrl.wdata = rdata;
      end
      ST_ZERO_ADR: begin
        addr_req.en  = 1'b1;
        addr_req.row = LAST_ROW;
        addr_req.col = walk_col;
      end
      ST_ZERO_WR: begin
        mem_ctrl.we    = 1'b1;
        mem_ctrl.wdata = '0;
      end
      ST_RD_DATA, ST_FINISH: ;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR_ADR;
      booting   <= 1'b1;
      cur_col   <= '0;
      cur_row   <= '0;
      walk_col  <= '0;
      walk_row  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_CLR_WR) && walk_row_end && walk_col_end) booting <= 1'b0;

      if ((state == ST_FINISH) && out_free) out_valid <= 1'b1;
      else if (out_ready)                   out_valid <= 1'b0;

      unique case (state)
        ST_DECODE: begin
          walk_col <= '0;
          walk_row <= (item.func == FUNC_CLEAR) ? '0 : ROW_W'(1);
          if (item.func == FUNC_CLEAR) begin
            cur_col <= '0;
            cur_row <= '0;
          end else if ((item.func == FUNC_PUT) && !bad) begin
            cur_col <= new_col;
            cur_row <= wrap ? LAST_ROW : new_row_ext[ROW_W-1:0];
          end
        end
        ST_CLR_WR, ST_SCR_WR: begin
          if (walk_row_end && walk_col_end) begin
            walk_col <= '0;
            walk_row <= '0;
          end else if (walk_col_end) begin
            walk_col <= '0;
            walk_row <= walk_row + 1'b1;
          end else begin
            walk_col <= walk_col + 1'b1;
          end
        end
        ST_ZERO_WR: walk_col <= walk_col + 1'b1;
        default: ;
      endcase
    end
  end

  // word and result registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= in_data;
    if (state == ST_DECODE) begin
      res_oor  <= bad && ((item.func == FUNC_PUT) || (item.func == FUNC_READ));
      res_scr  <= (item.func == FUNC_PUT) && !bad && wrap;
      res_char <= '0;
      res_attr <= '0;
    end
    if (state == ST_RD_DATA) begin
      res_char <= rdata[15:8];
      res_attr <= rdata[7:0];
    end
    if ((state == ST_FINISH) && out_free) begin
      out_data.cursor_col   <= cur_col;
      out_data.cursor_row   <= cur_row;
      out_data.out_of_range <= res_oor;
      out_data.scrolled     <= res_scr;
      out_data.cell_char    <= res_char;
      out_data.cell_attr    <= res_attr;
    end
  end

endmodule

/* sv/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tcw_pkg::out_item_t  out_data
);
  import tcw_pkg::*;

  // held result word must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // store sweep after reset keeps the input closed
  a_boot_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open during reset sweep");

  // one word at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // cursor stays on the grid
  a_cursor_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cursor_col < COL_W'(COLS)) &&
                  ({1'b0, out_data.cursor_row} < (ROW_W + 1)'(ROWS)))
    else $error("cursor off the grid");

  // a scroll leaves the cursor on the last row, never with an error
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.scrolled |->
      (out_data.cursor_row == ROW_W'(ROWS - 1)) && !out_data.out_of_range)
    else $error("bad cursor after scroll");

endmodule

bind text_console_writer_top tcw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

/* tb/text_console_writer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches both channels of the console writer. Keeps a shadow screen and
// cursor, predicts the status word of every accepted word and compares
// each returned word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module text_console_writer_checker #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  tcw_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  tcw_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending,
  output int                 checked,
  output int                 scrolls,
  output int                 cell_reads
);
  import tcw_pkg::*;

  localparam int NCELLS = COLS * ROWS;

  logic [7:0]  shadow_char [NCELLS];
  logic [7:0]  shadow_attr [NCELLS];
  int unsigned shadow_cursor;
  out_item_t   status_q [$];
  int          err_cnt;
  int          chk_cnt;
  int          scr_cnt;
  int          rd_cnt;

  function automatic void blank_screen();
    for (int i = 0; i < NCELLS; i++) begin
      shadow_char[i] = SPACE_CHAR;
      shadow_attr[i] = DEF_ATTR;
    end
  endfunction

  // row r moves to row r-1, last row goes to all zero
  function automatic void scroll_screen();
    for (int r = 1; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        shadow_char[(r - 1) * COLS + c] = shadow_char[r * COLS + c];
        shadow_attr[(r - 1) * COLS + c] = shadow_attr[r * COLS + c];
      end
    end
    for (int c = 0; c < COLS; c++) begin
      shadow_char[(ROWS - 1) * COLS + c] = 8'h00;
      shadow_attr[(ROWS - 1) * COLS + c] = 8'h00;
    end
  endfunction

  function automatic out_item_t apply_console_word(in_item_t w);
    out_item_t   r;
    logic        bad;
    int unsigned pos;
    logic [7:0]  attr;
    r    = '0;
    bad  = !w.at_cursor && (w.col >= COLS || w.row >= ROWS);
    pos  = w.at_cursor ? shadow_cursor : (bad ? 0 : w.row * COLS + w.col);
    attr = (w.attr == 8'h00) ? DEF_ATTR : w.attr;
    case (w.func)
      FUNC_PUT: begin
        if (bad) begin
          shadow_char[NCELLS - 1] = ERR_CHAR;
          shadow_attr[NCELLS - 1] = ERR_ATTR;
          r.out_of_range = 1'b1;
        end else begin
          if (w.ch == NEWLINE_CHAR) begin
            pos = (pos / COLS + 1) * COLS;
          end else begin
            shadow_char[pos] = w.ch;
            shadow_attr[pos] = attr;
            pos++;
          end
          if (pos >= NCELLS) begin
            scroll_screen();
            pos -= COLS;
            r.scrolled = 1'b1;
          end
          shadow_cursor = pos;
        end
      end
      FUNC_CLEAR: begin
        blank_screen();
        shadow_cursor = 0;
      end
      FUNC_READ: begin
        if (bad) begin
          r.out_of_range = 1'b1;
        end else begin
          r.cell_char = shadow_char[pos];
          r.cell_attr = shadow_attr[pos];
        end
      end
      default: ;
    endcase
    r.cursor_col = COL_W'(shadow_cursor % COLS);
    r.cursor_row = ROW_W'(shadow_cursor / COLS);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < 30)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      blank_screen();
      shadow_cursor = 0;
      status_q.delete();
    end else begin
      // drain first: a word returned at this edge belongs to an older input
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("word with nothing pending", 32'(out_data), 32'd0);
        end else begin
          want = status_q.pop_front();
          chk_cnt++;
          if (out_data.cursor_col !== want.cursor_col)
            report_mismatch("cursor_col", 32'(out_data.cursor_col), 32'(want.cursor_col));
          if (out_data.cursor_row !== want.cursor_row)
            report_mismatch("cursor_row", 32'(out_data.cursor_row), 32'(want.cursor_row));
          if (out_data.out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", 32'(out_data.out_of_range),
                            32'(want.out_of_range));
          if (out_data.scrolled !== want.scrolled)
            report_mismatch("scrolled", 32'(out_data.scrolled), 32'(want.scrolled));
          if (out_data.cell_char !== want.cell_char)
            report_mismatch("cell_char", 32'(out_data.cell_char), 32'(want.cell_char));
          if (out_data.cell_attr !== want.cell_attr)
            report_mismatch("cell_attr", 32'(out_data.cell_attr), 32'(want.cell_attr));
        end
      end
      if (in_valid && in_ready) begin
        want = apply_console_word(in_data);
        status_q.push_back(want);
        if (want.scrolled)
          scr_cnt++;
        if (in_data.func == FUNC_READ && !want.out_of_range)
          rd_cnt++;
      end
    end
    errors     <= err_cnt;
    pending    <= status_q.size();
    checked    <= chk_cnt;
    scrolls    <= scr_cnt;
    cell_reads <= rd_cnt;
  end

endmodule

/* tb/tb_text_console_writer_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_top
// Drives put, clear, read and unused words into the console writer with
// random gaps and output stalls, including one long output hold-off; the
// checker predicts and compares every returned status word.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int         COLS        = DEF_COLS;
  localparam int         ROWS        = DEF_ROWS;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         RAND_WORDS  = 530;
  localparam int         LIMIT       = 20_000_000;
  localparam int         HOLD_AT     = 60;
  localparam int         HOLD_LEN    = 150;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      quiet     = 1'b0;

  int errors;
  int pending;
  int checked;
  int scrolls;
  int cell_reads;
  int words_sent = 0;
  int cycle_cnt  = 0;
  int taken_cnt  = 0;
  int hold_left  = 0;
  bit held       = 1'b0;

  always #6 clk = ~clk;

  text_console_writer_top #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  text_console_writer_checker #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .scrolls   (scrolls),
    .cell_reads(cell_reads)
  );

  function automatic in_item_t pack_word(logic [1:0] func, logic [7:0] ch, logic [7:0] attr,
                                         logic at_cursor, logic [7:0] col, logic [5:0] row);
    in_item_t w;
    w.func      = func;
    w.ch        = ch;
    w.attr      = attr;
    w.at_cursor = at_cursor;
    w.col       = col;
    w.row       = row;
    return w;
  endfunction

  // placement for put and read: cursor, in grid (biased to the last row), or off grid
  function automatic in_item_t place_word(in_item_t w);
    int roll;
    roll = $urandom_range(99);
    w.at_cursor = 1'b0;
    if (roll < 12) begin
      w.col = 8'($urandom_range(COLS, 255));
      w.row = 6'($urandom);
    end else if (roll < 22) begin
      w.col = 8'($urandom);
      w.row = 6'($urandom_range(ROWS, 63));
    end else if (roll < 35) begin
      w.at_cursor = 1'b1;
    end else if (roll < 65) begin
      w.row = 6'(ROWS - 1);
      w.col = ($urandom_range(1) == 0) ? 8'($urandom_range(COLS - 1))
                                       : 8'($urandom_range(COLS - 8, COLS - 1));
    end else begin
      w.col = 8'($urandom_range(COLS - 1));
      w.row = 6'($urandom_range(ROWS - 1));
    end
    return w;
  endfunction

  function automatic in_item_t random_word();
    in_item_t w;
    int       pick;
    pick        = $urandom_range(99);
    w.func      = FUNC_PUT;
    w.ch        = ($urandom_range(9) == 0) ? NEWLINE_CHAR : 8'($urandom);
    w.attr      = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom);
    w.at_cursor = 1'b1;
    w.col       = 8'($urandom);
    w.row       = 6'($urandom);
    if (pick < 45) begin
      // typed text at the cursor
    end else if (pick < 60) begin
      w = place_word(w);
    end else if (pick < 87) begin
      w.func = FUNC_READ;
      w = place_word(w);
    end else if (pick < 90) begin
      w.func = FUNC_CLEAR;
      w.at_cursor = 1'($urandom);
    end else if (pick < 93) begin
      w.func = FUNC_UNUSED;
      w.at_cursor = 1'($urandom);
    end else begin
      w.ch = NEWLINE_CHAR;
    end
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    while (!quiet && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        taken_cnt++;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && taken_cnt == HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b0, 8'h00, 6'h00));
    send_word(pack_word(FUNC_PUT, 8'h41, 8'h00, 1'b0, 8'h00, 6'h00));
    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b0, 8'h00, 6'h00));
    // last cell: the write itself runs past the end and scrolls
    send_word(pack_word(FUNC_PUT, 8'hff, 8'hff, 1'b0, 8'(COLS - 1), 6'(ROWS - 1)));
    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b0, 8'(COLS - 1), 6'(ROWS - 2)));
    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b0, 8'h00, 6'(ROWS - 1)));
    send_word(pack_word(FUNC_PUT, 8'h5a, 8'h12, 1'b0, 8'(COLS), 6'h00));
    send_word(pack_word(FUNC_PUT, 8'h00, 8'h00, 1'b0, 8'hff, 6'h3f));
    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b0, 8'(COLS - 1), 6'(ROWS - 1)));
    send_word(pack_word(FUNC_READ, 8'hff, 8'hff, 1'b0, 8'hff, 6'h3f));
    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b0, 8'h00, 6'(ROWS)));
    // newline on the bottom row scrolls
    send_word(pack_word(FUNC_PUT, NEWLINE_CHAR, 8'h00, 1'b1, 8'h00, 6'h00));
    send_word(pack_word(FUNC_PUT, 8'h78, 8'h3c, 1'b1, 8'hff, 6'h3f));
    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b1, 8'hff, 6'h3f));
    send_word(pack_word(FUNC_UNUSED, 8'hff, 8'hff, 1'b1, 8'hff, 6'h3f));
    send_word(pack_word(FUNC_PUT, NEWLINE_CHAR, 8'h07, 1'b0, 8'h05, 6'h03));
    send_word(pack_word(FUNC_PUT, 8'h00, 8'h01, 1'b1, 8'h00, 6'h00));
    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b0, 8'h00, 6'h04));
    send_word(pack_word(FUNC_CLEAR, 8'hff, 8'hff, 1'b1, 8'hff, 6'h3f));
    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b0, 8'(COLS - 1), 6'(ROWS - 1)));
    send_word(pack_word(FUNC_READ, 8'h00, 8'h00, 1'b1, 8'h00, 6'h00));
    send_word(pack_word(FUNC_PUT, SPACE_CHAR, 8'h80, 1'b1, 8'h00, 6'h00));

    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == 250)
        quiet <= 1'b1;
      else if (i == 330)
        quiet <= 1'b0;
      send_word(random_word());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);

    $display("%0d words sent, %0d status words checked", words_sent, checked);
    $display("%0d screen scrolls, %0d in-grid cell reads", scrolls, cell_reads);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
